### src/c80alu_pkg.sv
// Package with the command codes and stage record types of the 8080-style ALU.
`timescale 1ns / 1ps

package c80alu_pkg;

	// Operation codes carried on the command port.
	typedef enum logic [4:0] {
		CMD_ADD = 5'd0,
		CMD_ADC = 5'd1,
		CMD_SUB = 5'd2,
		CMD_SBB = 5'd3,
		CMD_AND = 5'd4,
		CMD_XOR = 5'd5,
		CMD_OR  = 5'd6,
		CMD_CMP = 5'd7,
		CMD_INC = 5'd8,
		CMD_DEC = 5'd9,
		CMD_DAA = 5'd10,
		CMD_RLC = 5'd11,
		CMD_RRC = 5'd12,
		CMD_RAL = 5'd13,
		CMD_RAR = 5'd14,
		CMD_CMA = 5'd15,
		CMD_CMC = 5'd16,
		CMD_STC = 5'd17
	} cmd_t;

	// Where the new carry flag comes from.
	typedef enum logic [1:0] {
		CY_FIXED  = 2'd0,
		CY_SUM    = 2'd1,
		CY_BORROW = 2'd2
	} cy_sel_t;

	// Decimal adjust constants and the increment and decrement addends.
	localparam logic [3:0] DAA_DIGIT_MAX = 4'd9;
	localparam logic [7:0] DAA_CORR_LO   = 8'h06;
	localparam logic [7:0] DAA_CORR_HI   = 8'h60;
	localparam logic [7:0] DEC_ADDEND    = 8'hFE;
	localparam logic [7:0] INC_ADDEND    = 8'h01;

	// Decoded operation: adder operands plus everything else already resolved.
	typedef struct packed {
		logic [7:0] x;
		logic [7:0] y;
		logic       cin;
		logic [7:0] alt;
		cy_sel_t    cy_sel;
		logic       cy_fix;
		logic       ac_from_sum;
		logic       ac_fix;
		logic       res_from_sum;
		logic       flg_from_sum;
		logic       szp;
		logic       z_in;
		logic       s_in;
		logic       p_in;
	} op_t;

	// Result byte with carry flags, and the byte the other flags come from.
	typedef struct packed {
		logic [7:0] res;
		logic [7:0] flg_src;
		logic       cy;
		logic       ac;
		logic       szp;
		logic       z_in;
		logic       s_in;
		logic       p_in;
	} exec_t;

	// Final word presented at the outputs.
	typedef struct packed {
		logic [7:0] res;
		logic       cy;
		logic       ac;
		logic       z;
		logic       s;
		logic       p;
	} out_t;

endpackage

### src/c80alu_decode.sv
// First pipeline stage: decodes the command into adder operands and flag selects.
`timescale 1ns / 1ps

module c80alu_decode (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                valid,
	input  logic [4:0]          command,
	input  logic [7:0]          accumulator,
	input  logic [7:0]          operand,
	input  logic                carry_in,
	input  logic                aux_carry_in,
	input  logic                zero_in,
	input  logic                sign_in,
	input  logic                parity_in,
	output logic                valid_s1,
	output c80alu_pkg::op_t     op_s1
);
	import c80alu_pkg::*;

	op_t        op;
	logic       lo_big;
	logic       hi_corr;
	logic [7:0] corr;

	// Decimal adjust correction is chosen from the accumulator and the incoming carry and auxiliary carry.
	always_comb begin
		lo_big  = accumulator[3:0] > DAA_DIGIT_MAX;
		hi_corr = carry_in || (accumulator[7:4] > DAA_DIGIT_MAX)
			|| ((accumulator[7:4] >= DAA_DIGIT_MAX) && lo_big);
		corr    = ((lo_big || aux_carry_in) ? DAA_CORR_LO : 8'h00)
			| (hi_corr ? DAA_CORR_HI : 8'h00);
	end

	always_comb begin
		op.x            = accumulator;
		op.y            = operand;
		op.cin          = 1'b0;
		op.alt          = accumulator;
		op.cy_sel       = CY_FIXED;
		op.cy_fix       = carry_in;
		op.ac_from_sum  = 1'b0;
		op.ac_fix       = aux_carry_in;
		op.res_from_sum = 1'b0;
		op.flg_from_sum = 1'b0;
		op.szp          = 1'b0;
		op.z_in         = zero_in;
		op.s_in         = sign_in;
		op.p_in         = parity_in;
		case (cmd_t'(command))
			CMD_ADD, CMD_ADC: begin
				op.cin          = (cmd_t'(command) == CMD_ADC) ? carry_in : 1'b0;
				op.cy_sel       = CY_SUM;
				op.ac_from_sum  = 1'b1;
				op.res_from_sum = 1'b1;
				op.flg_from_sum = 1'b1;
				op.szp          = 1'b1;
			end
			CMD_SUB, CMD_SBB, CMD_CMP: begin
				op.y            = ~operand;
				op.cin          = (cmd_t'(command) == CMD_SBB) ? ~carry_in : 1'b1;
				op.cy_sel       = CY_BORROW;
				op.ac_from_sum  = 1'b1;
				op.res_from_sum = cmd_t'(command) != CMD_CMP;
				op.flg_from_sum = 1'b1;
				op.szp          = 1'b1;
			end
			CMD_AND: begin
				op.alt    = accumulator & operand;
				op.cy_fix = 1'b0;
				op.ac_fix = accumulator[3] | operand[3];
				op.szp    = 1'b1;
			end
			CMD_XOR: begin
				op.alt    = accumulator ^ operand;
				op.cy_fix = 1'b0;
				op.ac_fix = 1'b0;
				op.szp    = 1'b1;
			end
			CMD_OR: begin
				op.alt    = accumulator | operand;
				op.cy_fix = 1'b0;
				op.ac_fix = 1'b0;
				op.szp    = 1'b1;
			end
			CMD_INC, CMD_DEC: begin
				op.x            = operand;
				op.y            = (cmd_t'(command) == CMD_INC) ? INC_ADDEND : DEC_ADDEND;
				op.cin          = cmd_t'(command) == CMD_DEC;
				op.ac_from_sum  = 1'b1;
				op.res_from_sum = 1'b1;
				op.flg_from_sum = 1'b1;
				op.szp          = 1'b1;
			end
			CMD_DAA: begin
				op.y            = corr;
				op.cy_fix       = hi_corr;
				op.ac_from_sum  = 1'b1;
				op.res_from_sum = 1'b1;
				op.flg_from_sum = 1'b1;
				op.szp          = 1'b1;
			end
			CMD_RLC: begin
				op.alt    = {accumulator[6:0], accumulator[7]};
				op.cy_fix = accumulator[7];
			end
			CMD_RRC: begin
				op.alt    = {accumulator[0], accumulator[7:1]};
				op.cy_fix = accumulator[0];
			end
			CMD_RAL: begin
				op.alt    = {accumulator[6:0], carry_in};
				op.cy_fix = accumulator[7];
			end
			CMD_RAR: begin
				op.alt    = {carry_in, accumulator[7:1]};
				op.cy_fix = accumulator[0];
			end
			CMD_CMA: begin
				op.alt = ~accumulator;
			end
			CMD_CMC: begin
				op.cy_fix = ~carry_in;
			end
			CMD_STC: begin
				op.cy_fix = 1'b1;
			end
			default: begin
				op.cy_fix = carry_in;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= valid;
		end
	end

	always_ff @(posedge clk) begin
		op_s1 <= op;
	end

endmodule

### src/c80alu_exec.sv
// Second pipeline stage: the 8-bit adder and the result byte and carry selection.
`timescale 1ns / 1ps

module c80alu_exec (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                valid_s1,
	input  c80alu_pkg::op_t     op_s1,
	output logic                valid_s2,
	output c80alu_pkg::exec_t   ex_s2
);
	import c80alu_pkg::*;

	logic [8:0] sum;
	logic [4:0] nib;
	exec_t      ex;

	always_comb begin
		sum = {1'b0, op_s1.x} + {1'b0, op_s1.y} + {8'd0, op_s1.cin};
		nib = {1'b0, op_s1.x[3:0]} + {1'b0, op_s1.y[3:0]} + {4'd0, op_s1.cin};
		ex.res     = op_s1.res_from_sum ? sum[7:0] : op_s1.alt;
		ex.flg_src = op_s1.flg_from_sum ? sum[7:0] : op_s1.alt;
		case (op_s1.cy_sel)
			CY_SUM:    ex.cy = sum[8];
			CY_BORROW: ex.cy = ~sum[8];
			default:   ex.cy = op_s1.cy_fix;
		endcase
		ex.ac   = op_s1.ac_from_sum ? nib[4] : op_s1.ac_fix;
		ex.szp  = op_s1.szp;
		ex.z_in = op_s1.z_in;
		ex.s_in = op_s1.s_in;
		ex.p_in = op_s1.p_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		ex_s2 <= ex;
	end

endmodule

### src/c80alu_flags.sv
// Third pipeline stage: zero, sign and parity flags and the output register.
`timescale 1ns / 1ps

module c80alu_flags (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                valid_s2,
	input  c80alu_pkg::exec_t   ex_s2,
	output logic                valid_s3,
	output c80alu_pkg::out_t    out_s3
);
	import c80alu_pkg::*;

	out_t fl;

	always_comb begin
		fl.res = ex_s2.res;
		fl.cy  = ex_s2.cy;
		fl.ac  = ex_s2.ac;
		fl.z   = ex_s2.szp ? (ex_s2.flg_src == 8'h00) : ex_s2.z_in;
		fl.s   = ex_s2.szp ? ex_s2.flg_src[7] : ex_s2.s_in;
		fl.p   = ex_s2.szp ? ~^ex_s2.flg_src : ex_s2.p_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		out_s3 <= fl;
	end

endmodule

### src/cpu8080_alu_flags.sv
// Top level of the pipelined 8080-style ALU with flag generation.
`timescale 1ns / 1ps

// This ALU takes one word per clock: a word is accepted at any rising edge with
// start high, and busy is never raised, so a new operation may follow in every
// cycle. Each word passes through three register stages (decode, add and
// select, flag generation). Its result is on the result ports with done high
// for a single cycle, while it is held in the output register of flag generation.
// The receiver cannot hold results off, and the block never needs it to:
// results leave in the order the words came in, one per cycle at most. The
// latency is set by the three stages; throughput is one word per clock.
// Flags an operation does not touch are passed through from the incoming flags.
module cpu8080_alu_flags (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [4:0] command,
	input  logic [7:0] accumulator,
	input  logic [7:0] operand,
	input  logic       carry_in,
	input  logic       aux_carry_in,
	input  logic       zero_in,
	input  logic       sign_in,
	input  logic       parity_in,
	output logic       done,
	output logic [7:0] result,
	output logic       carry_out,
	output logic       aux_carry_out,
	output logic       zero_out,
	output logic       sign_out,
	output logic       parity_out
);
	import c80alu_pkg::*;

	logic  valid_s1;
	logic  valid_s2;
	logic  valid_s3;
	op_t   op_s1;
	exec_t ex_s2;
	out_t  out_s3;

	// Nothing downstream can stall, so the pipeline is always free to accept.
	assign busy = 1'b0;

	// Stage one resolves the command into adder operands and flag selects.
	c80alu_decode u_decode (
		.clk          (clk),
		.arst_n       (arst_n),
		.valid        (start),
		.command      (command),
		.accumulator  (accumulator),
		.operand      (operand),
		.carry_in     (carry_in),
		.aux_carry_in (aux_carry_in),
		.zero_in      (zero_in),
		.sign_in      (sign_in),
		.parity_in    (parity_in),
		.valid_s1     (valid_s1),
		.op_s1        (op_s1)
	);

	// Stage two runs the adder and picks the result byte and carry flags.
	c80alu_exec u_exec (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.op_s1    (op_s1),
		.valid_s2 (valid_s2),
		.ex_s2    (ex_s2)
	);

	// Stage three derives zero, sign and parity and holds the output word.
	c80alu_flags u_flags (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s2 (valid_s2),
		.ex_s2    (ex_s2),
		.valid_s3 (valid_s3),
		.out_s3   (out_s3)
	);

	assign done          = valid_s3;
	assign result        = out_s3.res;
	assign carry_out     = out_s3.cy;
	assign aux_carry_out = out_s3.ac;
	assign zero_out      = out_s3.z;
	assign sign_out      = out_s3.s;
	assign parity_out    = out_s3.p;

	// Every accepted word produces its result with done high once it has passed the decode, add and flag registers.
	a_latency : assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##3 done)
		else $error("accepted word did not complete after three cycles");

	// Compare leaves the accumulator as the result byte.
	a_cmp_keeps_acc : assert property (@(posedge clk) disable iff (!arst_n)
		(start && command == CMD_CMP) |-> ##3 (result == $past(accumulator, 3)))
		else $error("compare changed the result byte");

	// Set carry always yields a carry flag of one.
	a_stc_sets_carry : assert property (@(posedge clk) disable iff (!arst_n)
		(start && command == CMD_STC) |-> ##3 carry_out)
		else $error("set carry did not set the carry flag");

endmodule
